FILE: hw/rtl/rse_pkg.sv
// Shared constants, payload types, state and command codes for the rANS escape encoder.
package rse_pkg;

  localparam int PROB_BITS      = 16;
  localparam int BYPASS_BITS    = 4;
  localparam int STATE_W        = 64;
  localparam int WORD_W         = 32;
  localparam int SYM_W          = 16;
  localparam int RAW_W          = SYM_W + 2;
  localparam int NDIG_MAX       = (RAW_W + BYPASS_BITS - 1) / BYPASS_BITS;
  localparam int RAW_PAD_W      = NDIG_MAX * BYPASS_BITS;
  localparam int NDIG_W         = $clog2(NDIG_MAX + 1);
  localparam int DIG_IDX_W      = (NDIG_MAX > 1) ? $clog2(NDIG_MAX) : 1;
  localparam int CHUNK          = (1 << BYPASS_BITS) - 1;
  localparam int FREQ_W         = PROB_BITS + 1;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = STATE_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_INDEX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_OFFSET = 1'd1;

  typedef struct packed {
    logic signed [SYM_W-1:0] symbol_value;
    logic [15:0]             cdf_start;
    logic [15:0]             cdf_range;
    logic                    end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              run_last;
    logic              is_flush_word;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIGIT, ST_COUNT, ST_CHUNK, ST_SREN, ST_DIV,
    ST_UPDATE, ST_FLUSH_HI, ST_FLUSH_LO, ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIGIT, OP_COUNT, OP_CHUNK, OP_SREN, OP_DIV,
    OP_UPDATE, OP_FLUSH_HI, OP_FLUSH_LO, OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic esc;
    logic ndig_zero;
    logic dig_last;
    logic quo_zero;
    logic quo_one;
    logic div_last;
    logic eos;
    logic step_ok;
  } status_t;

endpackage

FILE: hw/rtl/rse_ctrl.sv
// Sequencer that walks one transaction through escape digits, symbol coding and flush.
module rse_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rse_pkg::status_t st_i,
  output rse_pkg::cmd_t   cmd_o
);
  import rse_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!st_i.esc)           state_d = ST_SREN;
        else if (st_i.ndig_zero) state_d = ST_COUNT;
        else                     state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd_o.op = OP_DIGIT;
        if (st_i.step_ok && st_i.dig_last) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        cmd_o.op = OP_COUNT;
        if (st_i.step_ok) state_d = st_i.quo_zero ? ST_SREN : ST_CHUNK;
      end
      ST_CHUNK: begin
        cmd_o.op = OP_CHUNK;
        if (st_i.step_ok && st_i.quo_one) state_d = ST_SREN;
      end
      ST_SREN: begin
        cmd_o.op = OP_SREN;
        if (st_i.step_ok) state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (st_i.div_last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = st_i.eos ? ST_FLUSH_HI : ST_FINISH;
      end
      ST_FLUSH_HI: begin
        cmd_o.op = OP_FLUSH_HI;
        if (st_i.step_ok) state_d = ST_FLUSH_LO;
      end
      ST_FLUSH_LO: begin
        cmd_o.op = OP_FLUSH_LO;
        if (st_i.step_ok) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.op = OP_FINISH;
        if (st_i.step_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/rse_datapath.sv
// Coder state, symbol folding, radix-16 divider and word output staging.
module rse_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rse_pkg::in_item_t             in_data_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rse_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rse_pkg::out_item_t            out_data_o,
  input  rse_pkg::cmd_t                 cmd_i,
  output rse_pkg::status_t              st_o
);
  import rse_pkg::*;

  logic [15:0]              esc_idx_q;
  logic signed [SYM_W-1:0]  sym_off_q;
  logic [STATE_W-1:0]       x_q;
  logic [RAW_PAD_W-1:0]     raw_pad_q;
  logic                     esc_q, ndig_zero_q, eos_q;
  logic [DIG_IDX_W-1:0]     dig_q;
  logic [NDIG_W-1:0]        rem_q, quo_q;
  logic [FREQ_W-1:0]        freq_q;
  logic [15:0]              start_q;
  logic [FREQ_W-1:0]        r_q;
  logic [DIV_CNT_W-1:0]     div_cnt_q;
  logic [WORD_W-1:0]        pend_word_q;
  logic                     pend_flush_q, pend_v_q;
  out_item_t                out_q;
  logic                     out_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_idx_q <= '0;
      sym_off_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ESCAPE_INDEX:  esc_idx_q <= cfg_data_i;
        CFG_SYMBOL_OFFSET: sym_off_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Fold the incoming symbol into an unsigned raw value
  logic signed [SYM_W:0]   v;
  logic signed [SYM_W+1:0] v_ext, esc_ext, v_minus;
  logic                    f_neg, f_over;
  logic [RAW_W-1:0]        raw_in;
  logic [RAW_PAD_W-1:0]    raw_in_pad;
  logic [NDIG_W-1:0]       ndig_in;
  logic [FREQ_W-1:0]       freq_in;

  always_comb begin
    v       = $signed({in_data_i.symbol_value[SYM_W-1], in_data_i.symbol_value})
            - $signed({sym_off_q[SYM_W-1], sym_off_q});
    v_ext   = {v[SYM_W], v};
    esc_ext = $signed({2'b00, esc_idx_q});
    v_minus = v_ext - esc_ext;
    f_neg   = v[SYM_W];
    f_over  = !f_neg && (v_ext >= esc_ext);
    if (f_neg) raw_in = RAW_W'(~{v, 1'b0});
    else       raw_in = RAW_W'({v_minus, 1'b0});
    raw_in_pad = RAW_PAD_W'(raw_in);
    ndig_in = '0;
    for (int i = 0; i < NDIG_MAX; i++) begin
      if (|raw_in_pad[i*BYPASS_BITS +: BYPASS_BITS]) ndig_in = NDIG_W'(i + 1);
    end
    if (in_data_i.cdf_range == '0 || FREQ_W'(in_data_i.cdf_range) > FREQ_W'(1 << PROB_BITS))
      freq_in = FREQ_W'(1 << PROB_BITS);
    else
      freq_in = FREQ_W'(in_data_i.cdf_range);
  end

  // Renorm checks and bypass-bit update
  logic                   out_free, emit_ok, need_bits, need_sym;
  logic [BYPASS_BITS-1:0] bits_val;
  logic [STATE_W-1:0]     x_bits_src, x_bits_next;

  assign out_free  = !out_v_q || out_ready_i;
  assign emit_ok   = !pend_v_q || out_free;
  assign need_bits = |x_q[STATE_W-1:STATE_W-1-BYPASS_BITS];
  assign need_sym  = x_q[STATE_W-1:STATE_W-1-PROB_BITS] >= freq_q;

  always_comb begin
    case (cmd_i.op)
      OP_DIGIT: bits_val = raw_pad_q[dig_q*BYPASS_BITS +: BYPASS_BITS];
      OP_COUNT: bits_val = BYPASS_BITS'(rem_q);
      default:  bits_val = BYPASS_BITS'(CHUNK);
    endcase
    x_bits_src  = need_bits ? {{WORD_W{1'b0}}, x_q[STATE_W-1:WORD_W]} : x_q;
    x_bits_next = (x_bits_src << BYPASS_BITS) | STATE_W'(bits_val);
  end

  // Four restoring-division steps per cycle
  logic [FREQ_W:0]             div_t;
  logic [FREQ_W-1:0]           div_r;
  logic [DIV_RADIX_BITS-1:0]   div_qb;

  always_comb begin
    div_r  = r_q;
    div_qb = '0;
    div_t  = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      div_t = {div_r, x_q[STATE_W-1-k]};
      if (div_t >= {1'b0, freq_q}) begin
        div_t = div_t - {1'b0, freq_q};
        div_qb[DIV_RADIX_BITS-1-k] = 1'b1;
      end
      div_r = div_t[FREQ_W-1:0];
    end
  end

  // Step gating and word emission
  logic              step_ok, emit_req, emit_flush, fin_req, load_out;
  logic [WORD_W-1:0] emit_word;

  always_comb begin
    emit_req   = 1'b0;
    emit_flush = 1'b0;
    emit_word  = x_q[WORD_W-1:0];
    fin_req    = 1'b0;
    step_ok    = 1'b1;
    case (cmd_i.op)
      OP_DIGIT, OP_COUNT, OP_CHUNK: begin
        emit_req = need_bits;
        step_ok  = !need_bits || emit_ok;
      end
      OP_SREN: begin
        emit_req = need_sym;
        step_ok  = !need_sym || emit_ok;
      end
      OP_FLUSH_HI: begin
        emit_req   = 1'b1;
        emit_flush = 1'b1;
        emit_word  = x_q[STATE_W-1:WORD_W];
        step_ok    = emit_ok;
      end
      OP_FLUSH_LO: begin
        emit_req   = 1'b1;
        emit_flush = 1'b1;
        step_ok    = emit_ok;
      end
      OP_FINISH: begin
        fin_req = 1'b1;
        step_ok = !pend_v_q || out_free;
      end
      default: ;
    endcase
  end

  // held word moves to the output register on a new emit or at finish
  assign load_out = step_ok && pend_v_q && (emit_req || fin_req);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q          <= STATE_W'(64'd1 << 31);
      pend_word_q  <= '0;
      pend_flush_q <= 1'b0;
      pend_v_q     <= 1'b0;
      out_q        <= '0;
      out_v_q      <= 1'b0;
    end else begin
      if (load_out) begin
        out_q   <= '{out_word: pend_word_q, run_last: fin_req, is_flush_word: pend_flush_q};
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (step_ok && emit_req) begin
        pend_word_q  <= emit_word;
        pend_flush_q <= emit_flush;
        pend_v_q     <= 1'b1;
      end else if (step_ok && fin_req) begin
        pend_v_q <= 1'b0;
      end
      if (step_ok) begin
        case (cmd_i.op)
          OP_DIGIT, OP_COUNT, OP_CHUNK: x_q <= x_bits_next;
          OP_SREN:     if (need_sym) x_q <= {{WORD_W{1'b0}}, x_q[STATE_W-1:WORD_W]};
          OP_DIV:      x_q <= {x_q[STATE_W-1-DIV_RADIX_BITS:0], div_qb};
          OP_UPDATE:   x_q <= (x_q << PROB_BITS) + STATE_W'(r_q) + STATE_W'(start_q);
          OP_FLUSH_LO: x_q <= STATE_W'(64'd1 << 31);
          default: ;
        endcase
      end
    end
  end

  // Per-transaction payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      raw_pad_q   <= raw_in_pad;
      esc_q       <= f_neg || f_over;
      ndig_zero_q <= (ndig_in == '0);
      dig_q       <= DIG_IDX_W'(ndig_in - 1'b1);
      rem_q       <= ndig_in;
      quo_q       <= '0;
      freq_q      <= freq_in;
      start_q     <= in_data_i.cdf_start;
      eos_q       <= in_data_i.end_of_stream;
    end else begin
      // count-of-digits split into CHUNK-sized pieces, one subtract a cycle
      if (int'(rem_q) >= CHUNK) begin
        rem_q <= NDIG_W'(int'(rem_q) - CHUNK);
        quo_q <= quo_q + 1'b1;
      end else if (cmd_i.op == OP_CHUNK && step_ok) begin
        quo_q <= quo_q - 1'b1;
      end
      if (cmd_i.op == OP_DIGIT && step_ok) dig_q <= dig_q - 1'b1;
    end
    if (cmd_i.op == OP_SREN && step_ok) begin
      r_q       <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.op == OP_DIV) begin
      r_q       <= div_r;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  assign st_o = '{
    esc:       esc_q,
    ndig_zero: ndig_zero_q,
    dig_last:  (dig_q == '0),
    quo_zero:  (quo_q == '0),
    quo_one:   (quo_q == NDIG_W'(1)),
    div_last:  (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)),
    eos:       eos_q,
    step_ok:   step_ok
  };

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_load_pend_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_LOAD) |-> !pend_v_q) else $error("word held over into next transaction");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV) |-> (r_q < freq_q)) else $error("divider remainder out of range");

  a_finish_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FINISH && step_ok) |=> !pend_v_q) else $error("finish left a word pending");

endmodule

FILE: hw/rtl/rans_escape_symbol_encoder_unit.sv
// Top level of the 64-bit rANS encoder with escape coding of out-of-range symbols.
// One transaction in codes one symbol (fed in reverse stream order) into the 64-bit state and
// yields zero to nine 32-bit words out, in reverse reading order; run_last marks the final
// word of a transaction and is_flush_word the two state words written when end_of_stream is
// set, after which the state returns to 2^31. Symbols outside [0, escape_index) after
// subtracting symbol_offset are coded as the escape symbol, preceded (in coding order) by
// their folded raw value as 4-bit digits and a digit count. One transaction at a time is
// in flight, stepping through accept, dispatch, digits (escape only), count (escape only),
// renormalize, divide, state update, flush (only on end_of_stream) and finish; the output
// side can stall the steps that emit words and the finish. The divide by the symbol frequency,
// retiring 4 quotient bits a cycle, dominates. Words pass through a one-word hold stage
// (so the last word can be tagged) and a registered output stage; configuration writes
// are always accepted and must only be issued while the block is idle.
module rans_escape_symbol_encoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rse_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rse_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rse_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rse_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer: one state per coding phase
  rse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // coder state, divider, config registers and output staging
  rse_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule
